// ----- hdl/repeating_time_window_check_defines.svh -----
// assertion macros used by the rtwc_check checker
`ifndef REPEATING_TIME_WINDOW_CHECK_DEFINES_SVH
`define REPEATING_TIME_WINDOW_CHECK_DEFINES_SVH

// condition implies property in the same cycle, checked in reset too
`define RTWC_ASSERT_NOW(lbl, clk, cond, prop) \
    lbl: assert property (@(posedge clk) (cond) |-> (prop)) \
        else $error("rtwc check failed");

// condition implies property in the next cycle, checked in reset too
`define RTWC_ASSERT_NEXT(lbl, clk, cond, prop) \
    lbl: assert property (@(posedge clk) (cond) |=> (prop)) \
        else $error("rtwc check failed");

// condition implies property in the same cycle, out of reset only
`define RTWC_ASSERT_ON(lbl, clk, rst_n, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("rtwc check failed");

`endif

// ----- hdl/rtwc_pkg.sv -----
`timescale 1ns / 1ps
package rtwc_pkg;

    localparam int TIME_W     = 47;
    localparam int END_W      = 48;
    localparam int DAY_W      = 21;
    localparam int HOUR_W     = 5;
    localparam int CNT_W      = 16;
    localparam int UNIT_W     = 2;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 21;
    localparam int TOD_W      = 27;
    localparam int YEAR_W     = 13;
    localparam int MON_W      = 4;
    localparam int MDAY_W     = 5;

    localparam logic [TOD_W-1:0]  MS_PER_HOUR   = 27'd3600000;
    localparam logic [TOD_W-1:0]  MS_PER_DAY    = 27'd86400000;
    localparam logic [HOUR_W-1:0] HOURS_PER_DAY = 5'd24;

    // day split: ms / 86400000 = (ms >> 10) / 84375
    localparam int               DAY_SHIFT = 10;
    localparam logic [16:0]      DAY_ODD   = 17'd84375;
    localparam int               EST_DROP  = 15;
    localparam int               EST_FRAC  = 32;
    localparam logic [DAY_W-1:0] EST_M     = 21'((64'd1 << 37) / 64'd84375);

    // civil date constants
    localparam logic [21:0] Z_OFFSET = 22'd719468;
    localparam logic [21:0] ERA_DAYS = 22'd146097;
    localparam int          ERA_S    = 40;
    localparam logic [22:0] ERA_M    = 23'(((64'd1 << 40) + 64'd146096) / 64'd146097);
    localparam int          D1460_S  = 29;
    localparam logic [18:0] D1460_M  = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
    localparam int          D36524_S = 34;
    localparam logic [18:0] D36524_M = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
    localparam int          D146096_S = 36;
    localparam logic [18:0] D146096_M = 19'(((64'd1 << 36) + 64'd146095) / 64'd146096);
    localparam int          D365_S   = 27;
    localparam logic [18:0] D365_M   = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
    localparam int          D100_S   = 16;
    localparam logic [9:0]  D100_M   = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
    localparam int          D153_S   = 19;
    localparam logic [11:0] D153_M   = 12'(((64'd1 << 19) + 64'd152) / 64'd153);
    localparam int          D5_S     = 14;
    localparam logic [11:0] D5_M     = 12'(((64'd1 << 14) + 64'd4) / 64'd5);
    localparam int          CIV_LAT  = 7;

    // remainder pipeline
    localparam int REM_BPS    = 3;
    localparam int REM_STAGES = DAY_W / REM_BPS;

    localparam int CARRY_LEN = CIV_LAT + 1 + REM_STAGES;

    // repeat units
    localparam logic [UNIT_W-1:0] UNIT_NONE  = 2'd0;
    localparam logic [UNIT_W-1:0] UNIT_DAY   = 2'd1;
    localparam logic [UNIT_W-1:0] UNIT_MONTH = 2'd2;
    localparam logic [UNIT_W-1:0] UNIT_YEAR  = 2'd3;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_FIRST_DAY    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LAST_DAY     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_START_HOUR   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_END_HOUR     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_REPEAT_COUNT = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_REPEAT_UNIT  = 3'd5;

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [MON_W-1:0]  month;
        logic [MDAY_W-1:0] mday;
    } t_date;

    typedef struct packed {
        logic [DAY_W-1:0]  day;
        logic [TIME_W-1:0] mid;
        logic [TOD_W-1:0]  tod;
    } t_carry;

endpackage

// ----- hdl/repeating_time_window_check.sv -----
`timescale 1ns / 1ps
// channel   direction  ports                                         handshake
// query     in         i_time_ms                                     i_start & !o_busy
// result    out        o_is_inside, o_window_start_ms, o_window_end_ms   o_valid strobe
// config    in         i_cfg_addr, i_cfg_wdata                       i_cfg_we
//
// one query per cycle while o_busy is low; each result passes through the day split,
// the civil-date pipeline for the query day and the seven-stage remainder
// pipeline for the repeat period
// reset is synchronous; o_busy is high during reset and the cycle after it
// results are strobed for one cycle and cannot be held off
module repeating_time_window_check (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic [rtwc_pkg::TIME_W-1:0]         i_time_ms,
    output logic                                o_valid,
    output logic                                o_is_inside,
    output logic [rtwc_pkg::TIME_W-1:0]         o_window_start_ms,
    output logic [rtwc_pkg::END_W-1:0]          o_window_end_ms,
    input  logic                                i_cfg_we,
    input  logic [rtwc_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [rtwc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    localparam int LAST = rtwc_pkg::CARRY_LEN - 1;

    logic                            r_busy;
    logic [rtwc_pkg::DAY_W-1:0]      r_first_day;
    logic [rtwc_pkg::DAY_W-1:0]      r_last_day;
    logic [rtwc_pkg::HOUR_W-1:0]     r_start_hour;
    logic [rtwc_pkg::HOUR_W-1:0]     r_end_hour;
    logic [rtwc_pkg::CNT_W-1:0]      r_repeat_count;
    logic [rtwc_pkg::UNIT_W-1:0]     r_repeat_unit;
    logic [rtwc_pkg::TOD_W-1:0]      r_open_ms;
    logic [rtwc_pkg::TOD_W-1:0]      r_close_ms;
    logic [rtwc_pkg::HOUR_W-1:0]     n_sh;
    logic [rtwc_pkg::HOUR_W-1:0]     n_eh;

    logic                            r1_valid;
    logic [rtwc_pkg::TIME_W-1:0]     r1_time;
    logic [rtwc_pkg::DAY_W-1:0]      r1_est;
    logic [52:0]                     n1_prod;

    logic                            r2_valid;
    logic [18:0]                     r2_rem;
    logic [rtwc_pkg::DAY_W-1:0]      r2_est;
    logic [rtwc_pkg::DAY_SHIFT-1:0]  r2_low;
    logic [37:0]                     n2_back;

    logic                            r3_valid;
    logic [rtwc_pkg::DAY_W-1:0]      r3_day;
    logic [rtwc_pkg::TOD_W-1:0]      r3_tod;
    logic [1:0]                      n3_k;
    logic [18:0]                     n3_rem;

    logic [LAST:0]                   r_cv;
    rtwc_pkg::t_carry                r_carry [rtwc_pkg::CARRY_LEN];

    rtwc_pkg::t_date                 w_date_q;
    rtwc_pkg::t_date                 w_date_f;
    logic signed [13:0]              n_yd;
    logic signed [4:0]               n_md;
    logic signed [18:0]              n_mon;
    logic [rtwc_pkg::DAY_W-1:0]      n_dvd;
    logic                            n_ok;
    logic [rtwc_pkg::DAY_W-1:0]      r_dvd;
    logic [rtwc_pkg::REM_STAGES:0]   r_ok;
    logic [rtwc_pkg::CNT_W-1:0]      w_rem;

    rtwc_pkg::t_carry                n_c;
    logic                            n_active;
    logic                            n_inside;
    logic [rtwc_pkg::TOD_W-1:0]      n_a;
    logic [rtwc_pkg::TOD_W-1:0]      n_b;
    logic [rtwc_pkg::END_W-1:0]      n_ws;
    logic [rtwc_pkg::END_W-1:0]      n_we;

    logic                            r_out_valid;
    logic                            r_inside;
    logic [rtwc_pkg::TIME_W-1:0]     r_ws;
    logic [rtwc_pkg::END_W-1:0]      r_we;

    // control and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy         <= 1'b1;
            r_first_day    <= '0;
            r_last_day     <= '0;
            r_start_hour   <= '0;
            r_end_hour     <= rtwc_pkg::HOURS_PER_DAY;
            r_repeat_count <= '0;
            r_repeat_unit  <= rtwc_pkg::UNIT_NONE;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    rtwc_pkg::CFG_FIRST_DAY:    r_first_day    <= i_cfg_wdata;
                    rtwc_pkg::CFG_LAST_DAY:     r_last_day     <= i_cfg_wdata;
                    rtwc_pkg::CFG_START_HOUR:   r_start_hour   <= i_cfg_wdata[rtwc_pkg::HOUR_W-1:0];
                    rtwc_pkg::CFG_END_HOUR:     r_end_hour     <= i_cfg_wdata[rtwc_pkg::HOUR_W-1:0];
                    rtwc_pkg::CFG_REPEAT_COUNT: r_repeat_count <= i_cfg_wdata[rtwc_pkg::CNT_W-1:0];
                    rtwc_pkg::CFG_REPEAT_UNIT:  r_repeat_unit  <= i_cfg_wdata[rtwc_pkg::UNIT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_busy = r_busy | ~i_rst_n;

    // window edges in ms from midnight, hours saturate at a full day
    always_comb begin
        n_sh = (r_start_hour > rtwc_pkg::HOURS_PER_DAY) ? rtwc_pkg::HOURS_PER_DAY : r_start_hour;
        n_eh = (r_end_hour > rtwc_pkg::HOURS_PER_DAY) ? rtwc_pkg::HOURS_PER_DAY : r_end_hour;
    end

    always_ff @(posedge i_clk) begin
        r_open_ms  <= rtwc_pkg::TOD_W'(n_sh) * rtwc_pkg::MS_PER_HOUR;
        r_close_ms <= rtwc_pkg::TOD_W'(n_eh) * rtwc_pkg::MS_PER_HOUR;
    end

    // stage 1: day estimate, never above the true day
    assign n1_prod = 53'(i_time_ms[rtwc_pkg::TIME_W-1:rtwc_pkg::EST_DROP])
                   * 53'(rtwc_pkg::EST_M);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_start & ~o_busy;
        end
        r1_time <= i_time_ms;
        r1_est  <= n1_prod[rtwc_pkg::EST_FRAC +: rtwc_pkg::DAY_W];
    end

    // stage 2: what is left over the estimate
    assign n2_back = 38'(r1_est) * 38'(rtwc_pkg::DAY_ODD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
        r2_rem <= 19'(38'(r1_time[rtwc_pkg::TIME_W-1:rtwc_pkg::DAY_SHIFT]) - n2_back);
        r2_est <= r1_est;
        r2_low <= r1_time[rtwc_pkg::DAY_SHIFT-1:0];
    end

    // stage 3: up to three corrections
    always_comb begin
        if (r2_rem >= 19'(rtwc_pkg::DAY_ODD) * 19'd3) begin
            n3_k = 2'd3;
        end else if (r2_rem >= 19'(rtwc_pkg::DAY_ODD) * 19'd2) begin
            n3_k = 2'd2;
        end else if (r2_rem >= 19'(rtwc_pkg::DAY_ODD)) begin
            n3_k = 2'd1;
        end else begin
            n3_k = 2'd0;
        end
        n3_rem = r2_rem - 19'(n3_k) * 19'(rtwc_pkg::DAY_ODD);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
        r3_day <= r2_est + rtwc_pkg::DAY_W'(n3_k);
        r3_tod <= {n3_rem[16:0], r2_low};
    end

    // carry line alongside the calendar and remainder pipelines
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv <= '0;
        end else begin
            r_cv <= {r_cv[LAST-1:0], r3_valid};
        end
        r_carry[0].day <= r3_day;
        r_carry[0].mid <= rtwc_pkg::TIME_W'(48'(r3_day) * 48'(rtwc_pkg::MS_PER_DAY));
        r_carry[0].tod <= r3_tod;
        for (int i = 1; i < rtwc_pkg::CARRY_LEN; i++) begin
            r_carry[i] <= r_carry[i-1];
        end
    end

    rtwc_civil u_civil_q (
        .i_clk  (i_clk),
        .i_days (r3_day),
        .o_date (w_date_q)
    );

    rtwc_civil u_civil_f (
        .i_clk  (i_clk),
        .i_days (r_first_day),
        .o_date (w_date_f)
    );

    // repeat distance in the chosen unit
    always_comb begin
        n_yd  = $signed({1'b0, w_date_q.year}) - $signed({1'b0, w_date_f.year});
        n_md  = $signed({1'b0, w_date_q.month}) - $signed({1'b0, w_date_f.month});
        n_mon = 19'(n_yd) * 19'sd12 + 19'(n_md);
        unique case (r_repeat_unit)
            rtwc_pkg::UNIT_DAY: begin
                n_dvd = r_carry[rtwc_pkg::CIV_LAT-1].day - r_first_day;
                n_ok  = 1'b1;
            end
            rtwc_pkg::UNIT_MONTH: begin
                n_dvd = rtwc_pkg::DAY_W'(n_mon);
                n_ok  = (w_date_q.mday == w_date_f.mday) && (n_mon >= 0);
            end
            rtwc_pkg::UNIT_YEAR: begin
                n_dvd = rtwc_pkg::DAY_W'(n_yd);
                n_ok  = (w_date_q.mday == w_date_f.mday)
                     && (w_date_q.month == w_date_f.month) && (n_yd >= 0);
            end
            default: begin
                n_dvd = '0;
                n_ok  = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_ok  <= {r_ok[rtwc_pkg::REM_STAGES-1:0], n_ok};
    end

    rtwc_rem u_rem (
        .i_clk      (i_clk),
        .i_dividend (r_dvd),
        .i_divisor  (r_repeat_count),
        .o_rem      (w_rem)
    );

    // span selection
    always_comb begin
        n_c      = r_carry[LAST];
        n_active = (n_c.day >= r_first_day) && (n_c.day <= r_last_day)
                && ((r_repeat_unit == rtwc_pkg::UNIT_NONE)
                    || ((r_repeat_count != '0) && r_ok[rtwc_pkg::REM_STAGES]
                        && (w_rem == '0)));
        n_inside = 1'b0;
        if (!n_active) begin
            n_a = '0;
            n_b = rtwc_pkg::MS_PER_DAY;
        end else if (n_c.tod < r_open_ms) begin
            n_a = '0;
            n_b = r_open_ms;
        end else if (n_c.tod > r_close_ms) begin
            n_a = r_close_ms;
            n_b = rtwc_pkg::MS_PER_DAY;
        end else begin
            n_a      = r_open_ms;
            n_b      = r_close_ms;
            n_inside = 1'b1;
        end
        n_ws = rtwc_pkg::END_W'(n_c.mid) + rtwc_pkg::END_W'(n_a);
        n_we = rtwc_pkg::END_W'(n_c.mid) + rtwc_pkg::END_W'(n_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_cv[LAST];
        end
        r_inside <= n_inside;
        r_ws     <= n_ws[rtwc_pkg::TIME_W-1:0];
        r_we     <= n_we;
    end

    assign o_valid           = r_out_valid;
    assign o_is_inside       = r_inside;
    assign o_window_start_ms = r_ws;
    assign o_window_end_ms   = r_we;

endmodule

// ----- hdl/rtwc_civil.sv -----
`timescale 1ns / 1ps
module rtwc_civil (
    input  logic                           i_clk,
    input  logic [rtwc_pkg::DAY_W-1:0]     i_days,
    output rtwc_pkg::t_date                o_date
);

    logic [21:0] n1_z;
    logic [44:0] n1_prod;
    logic [21:0] r1_z;
    logic [4:0]  r1_era;

    logic [21:0] n2_era_days;
    logic [17:0] r2_doe;
    logic [4:0]  r2_era;

    logic [36:0] n3_pa;
    logic [36:0] n3_pb;
    logic [36:0] n3_pc;
    logic [17:0] r3_x;
    logic [17:0] r3_doe;
    logic [4:0]  r3_era;

    logic [36:0] n4_py;
    logic [8:0]  r4_yoe;
    logic [17:0] r4_doe;
    logic [4:0]  r4_era;

    logic [18:0] n5_p100;
    logic [17:0] n5_base;
    logic [8:0]  r5_doy;
    logic [8:0]  r5_yoe;
    logic [4:0]  r5_era;

    logic [10:0] n6_v;
    logic [22:0] n6_pm;
    logic [3:0]  r6_mp;
    logic [8:0]  r6_doy;
    logic [8:0]  r6_yoe;
    logic [4:0]  r6_era;

    logic [10:0] n7_w;
    logic [22:0] n7_pw;
    logic [3:0]  n7_m;
    rtwc_pkg::t_date r7_date;

    always_comb begin
        n1_z    = 22'(i_days) + rtwc_pkg::Z_OFFSET;
        n1_prod = 45'(n1_z) * 45'(rtwc_pkg::ERA_M);
    end

    always_ff @(posedge i_clk) begin
        r1_z   <= n1_z;
        r1_era <= n1_prod[rtwc_pkg::ERA_S +: 5];
    end

    assign n2_era_days = 22'(r1_era) * rtwc_pkg::ERA_DAYS;

    always_ff @(posedge i_clk) begin
        r2_doe <= 18'(r1_z - n2_era_days);
        r2_era <= r1_era;
    end

    // year of era, first the leap corrections
    always_comb begin
        n3_pa = 37'(r2_doe) * 37'(rtwc_pkg::D1460_M);
        n3_pb = 37'(r2_doe) * 37'(rtwc_pkg::D36524_M);
        n3_pc = 37'(r2_doe) * 37'(rtwc_pkg::D146096_M);
    end

    always_ff @(posedge i_clk) begin
        r3_x   <= r2_doe - 18'(n3_pa[36:rtwc_pkg::D1460_S])
                         + 18'(n3_pb[36:rtwc_pkg::D36524_S])
                         - 18'(n3_pc[36:rtwc_pkg::D146096_S]);
        r3_doe <= r2_doe;
        r3_era <= r2_era;
    end

    assign n4_py = 37'(r3_x) * 37'(rtwc_pkg::D365_M);

    always_ff @(posedge i_clk) begin
        r4_yoe <= n4_py[rtwc_pkg::D365_S +: 9];
        r4_doe <= r3_doe;
        r4_era <= r3_era;
    end

    always_comb begin
        n5_p100 = 19'(r4_yoe) * 19'(rtwc_pkg::D100_M);
        n5_base = 18'(r4_yoe) * 18'd365 + 18'(r4_yoe[8:2])
                - 18'(n5_p100[18:rtwc_pkg::D100_S]);
    end

    always_ff @(posedge i_clk) begin
        r5_doy <= 9'(r4_doe - n5_base);
        r5_yoe <= r4_yoe;
        r5_era <= r4_era;
    end

    // month counted from march
    always_comb begin
        n6_v  = 11'(r5_doy) * 11'd5 + 11'd2;
        n6_pm = 23'(n6_v) * 23'(rtwc_pkg::D153_M);
    end

    always_ff @(posedge i_clk) begin
        r6_mp  <= n6_pm[rtwc_pkg::D153_S +: 4];
        r6_doy <= r5_doy;
        r6_yoe <= r5_yoe;
        r6_era <= r5_era;
    end

    always_comb begin
        n7_w  = 11'(r6_mp) * 11'd153 + 11'd2;
        n7_pw = 23'(n7_w) * 23'(rtwc_pkg::D5_M);
        n7_m  = (r6_mp < 4'd10) ? r6_mp + 4'd3 : r6_mp - 4'd9;
    end

    always_ff @(posedge i_clk) begin
        r7_date.mday  <= 5'(r6_doy - 9'(n7_pw[22:rtwc_pkg::D5_S]) + 9'd1);
        r7_date.month <= n7_m;
        r7_date.year  <= 13'(r6_yoe) + 13'(r6_era) * 13'd400
                       + ((n7_m <= 4'd2) ? 13'd1 : 13'd0);
    end

    assign o_date = r7_date;

endmodule

// ----- hdl/rtwc_rem.sv -----
`timescale 1ns / 1ps
module rtwc_rem (
    input  logic                           i_clk,
    input  logic [rtwc_pkg::DAY_W-1:0]     i_dividend,
    input  logic [rtwc_pkg::CNT_W-1:0]     i_divisor,
    output logic [rtwc_pkg::CNT_W-1:0]     o_rem
);

    logic [rtwc_pkg::CNT_W-1:0] r_part [rtwc_pkg::REM_STAGES];
    logic [rtwc_pkg::DAY_W-1:0] r_dvd  [rtwc_pkg::REM_STAGES];

    for (genvar s = 0; s < rtwc_pkg::REM_STAGES; s++) begin : g_stage
        logic [rtwc_pkg::CNT_W-1:0] part_in;
        logic [rtwc_pkg::DAY_W-1:0] dvd_in;
        logic [rtwc_pkg::CNT_W-1:0] n_part;
        logic [rtwc_pkg::DAY_W-1:0] n_dvd;

        if (s == 0) begin : g_first
            assign part_in = '0;
            assign dvd_in  = i_dividend;
        end else begin : g_next
            assign part_in = r_part[s-1];
            assign dvd_in  = r_dvd[s-1];
        end

        // restoring steps, one dividend bit each
        always_comb begin
            logic [rtwc_pkg::CNT_W:0] acc;
            n_part = part_in;
            n_dvd  = dvd_in;
            acc    = '0;
            for (int b = 0; b < rtwc_pkg::REM_BPS; b++) begin
                acc   = {n_part, n_dvd[rtwc_pkg::DAY_W-1]};
                n_dvd = n_dvd << 1;
                if (acc >= {1'b0, i_divisor}) begin
                    acc = acc - {1'b0, i_divisor};
                end
                n_part = acc[rtwc_pkg::CNT_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            r_part[s] <= n_part;
            r_dvd[s]  <= n_dvd;
        end
    end

    assign o_rem = r_part[rtwc_pkg::REM_STAGES-1];

endmodule

// ----- hdl/rtwc_check.sv -----
`timescale 1ns / 1ps
`include "repeating_time_window_check_defines.svh"
module rtwc_check (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_busy,
    input logic                            o_valid,
    input logic                            o_is_inside,
    input logic [rtwc_pkg::TIME_W-1:0]     o_window_start_ms,
    input logic [rtwc_pkg::END_W-1:0]      o_window_end_ms
);

    // no query may be taken while in reset
    `RTWC_ASSERT_NOW(a_busy_in_reset, i_clk, !i_rst_n, o_busy)

    // nothing comes out right after reset
    `RTWC_ASSERT_NEXT(a_quiet_after_reset, i_clk, !i_rst_n, !o_valid)

    // a span never runs backwards
    `RTWC_ASSERT_ON(a_span_order, i_clk, i_rst_n, o_valid, o_window_end_ms >= 48'(o_window_start_ms))

    // a span never exceeds one day, an inside span included
    `RTWC_ASSERT_ON(a_span_len, i_clk, i_rst_n, o_valid || o_is_inside, (o_window_end_ms - 48'(o_window_start_ms)) <= 48'(rtwc_pkg::MS_PER_DAY) || !o_valid)

endmodule

bind repeating_time_window_check rtwc_check u_rtwc_check (.*);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb;

    localparam longint unsigned HOUR_MS  = 64'd3600000;
    localparam longint unsigned DAY_MS   = 64'd86400000;
    localparam longint unsigned TIME_MAX = (64'd1 << rtwc_pkg::TIME_W) - 1;
    localparam int              DRAIN_CYCLES = 25;
    localparam int              STALL_LIMIT  = 1000;

    typedef struct {
        bit                          is_in;
        logic [rtwc_pkg::TIME_W-1:0] win_start;
        logic [rtwc_pkg::END_W-1:0]  win_end;
    } t_window;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_start;
    logic                            o_busy;
    logic [rtwc_pkg::TIME_W-1:0]     i_time_ms;
    logic                            o_valid;
    logic                            o_is_inside;
    logic [rtwc_pkg::TIME_W-1:0]     o_window_start_ms;
    logic [rtwc_pkg::END_W-1:0]      o_window_end_ms;
    logic                            i_cfg_we;
    logic [rtwc_pkg::CFG_ADDR_W-1:0] i_cfg_addr;
    logic [rtwc_pkg::CFG_DATA_W-1:0] i_cfg_wdata;

    // schedule as the block should hold it
    longint unsigned sched_first, sched_last, sched_sh, sched_eh, sched_cnt, sched_unit;

    t_window window_q[$];
    int      errors;
    bit      idling;
    int      stall_cnt;

    repeating_time_window_check u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .o_busy            (o_busy),
        .i_time_ms         (i_time_ms),
        .o_valid           (o_valid),
        .o_is_inside       (o_is_inside),
        .o_window_start_ms (o_window_start_ms),
        .o_window_end_ms   (o_window_end_ms),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_wdata       (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic void to_civil(input longint unsigned days,
                                     output longint y, output longint m, output longint d);
        longint unsigned z, era, doe, yoe, doy, mp;
        z   = days + 64'd719468;
        era = z / 146097;
        doe = z - era * 146097;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp  = (5 * doy + 2) / 153;
        d   = longint'(doy - (153 * mp + 2) / 5 + 1);
        m   = (mp < 10) ? longint'(mp + 3) : longint'(mp - 9);
        y   = longint'(yoe + era * 400) + ((m <= 2) ? 1 : 0);
    endfunction

    function automatic longint unsigned from_civil(input longint y, input longint m,
                                                   input longint d);
        longint era, yoe, doy, doe;
        y   = y - ((m <= 2) ? 1 : 0);
        era = y / 400;
        yoe = y - era * 400;
        doy = (153 * ((m > 2) ? m - 3 : m + 9) + 2) / 5 + d - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return longint'(era * 146097 + doe - 719468);
    endfunction

    function automatic bit day_scheduled(input longint unsigned day);
        longint y1, m1, d1, y0, m0, d0, diff;
        if (day < sched_first || day > sched_last) return 1'b0;
        if (sched_unit == rtwc_pkg::UNIT_NONE) return 1'b1;
        if (sched_cnt == 0) return 1'b0;
        if (sched_unit == rtwc_pkg::UNIT_DAY) return ((day - sched_first) % sched_cnt) == 0;
        to_civil(day, y1, m1, d1);
        to_civil(sched_first, y0, m0, d0);
        if (d1 != d0) return 1'b0;
        if (sched_unit == rtwc_pkg::UNIT_MONTH) begin
            diff = 12 * (y1 - y0) + (m1 - m0);
        end else begin
            if (m1 != m0) return 1'b0;
            diff = y1 - y0;
        end
        if (diff < 0) return 1'b0;
        return (longint'(diff) % longint'(sched_cnt)) == 0;
    endfunction

    function automatic t_window predict_window(input longint unsigned t);
        t_window         w;
        longint unsigned day, mid, sh, eh, ws, we;
        day = t / DAY_MS;
        mid = day * DAY_MS;
        sh  = (sched_sh > 24) ? 24 : sched_sh;
        eh  = (sched_eh > 24) ? 24 : sched_eh;
        w.is_in = 1'b0;
        if (!day_scheduled(day)) begin
            ws = mid;
            we = mid + DAY_MS;
        end else begin
            ws = mid + sh * HOUR_MS;
            we = mid + eh * HOUR_MS;
            if (t < ws) begin
                we = ws;
                ws = mid;
            end else if (t > we) begin
                ws = we;
                we = mid + DAY_MS;
            end else begin
                w.is_in = 1'b1;
            end
        end
        w.win_start = ws[rtwc_pkg::TIME_W-1:0];
        w.win_end   = we[rtwc_pkg::END_W-1:0];
        return w;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_window w;
        if (i_rst_n && o_valid) begin
            if (window_q.size() == 0) begin
                report_mismatch("unexpected word", 1, 0);
            end else begin
                w = window_q.pop_front();
                if (o_is_inside !== w.is_in)
                    report_mismatch("is_inside", o_is_inside, w.is_in);
                if (o_window_start_ms !== w.win_start)
                    report_mismatch("window_start_ms", o_window_start_ms, w.win_start);
                if (o_window_end_ms !== w.win_end)
                    report_mismatch("window_end_ms", o_window_end_ms, w.win_end);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_valid || i_cfg_we) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("[repeating_time_window_check] ERROR");
                $finish;
            end
        end
    end

    task automatic send_query(input longint unsigned t);
        if (idling && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            i_start = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end else begin
            @(negedge i_clk);
        end
        i_start   = 1'b1;
        i_time_ms = t[rtwc_pkg::TIME_W-1:0];
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        window_q.push_back(predict_window(t & TIME_MAX));
    endtask

    task automatic drain_results;
        @(negedge i_clk);
        i_start = 1'b0;
        wait (window_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [rtwc_pkg::CFG_ADDR_W-1:0] idx,
                             input longint unsigned val);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_addr  = idx;
        i_cfg_wdata = val[rtwc_pkg::CFG_DATA_W-1:0];
        @(posedge i_clk);
        case (idx)
            rtwc_pkg::CFG_FIRST_DAY:    sched_first = val & 64'h1FFFFF;
            rtwc_pkg::CFG_LAST_DAY:     sched_last  = val & 64'h1FFFFF;
            rtwc_pkg::CFG_START_HOUR:   sched_sh    = val & 64'h1F;
            rtwc_pkg::CFG_END_HOUR:     sched_eh    = val & 64'h1F;
            rtwc_pkg::CFG_REPEAT_COUNT: sched_cnt   = val & 64'hFFFF;
            rtwc_pkg::CFG_REPEAT_UNIT:  sched_unit  = val & 64'h3;
            default: ;
        endcase
    endtask

    task automatic set_schedule(input longint unsigned first, input longint unsigned last,
                                input longint unsigned sh, input longint unsigned eh,
                                input longint unsigned cnt, input longint unsigned unit);
        drain_results();
        cfg_write(rtwc_pkg::CFG_FIRST_DAY, first);
        cfg_write(rtwc_pkg::CFG_LAST_DAY, last);
        cfg_write(rtwc_pkg::CFG_START_HOUR, sh);
        cfg_write(rtwc_pkg::CFG_END_HOUR, eh);
        cfg_write(rtwc_pkg::CFG_REPEAT_COUNT, cnt);
        cfg_write(rtwc_pkg::CFG_REPEAT_UNIT, unit);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic test_reset_defaults;
        send_query(0);
        send_query(DAY_MS - 1);
        send_query(DAY_MS);
        send_query(TIME_MAX);
        send_query(64'h5555_5555_5555 & TIME_MAX);
        send_query(64'h2AAA_AAAA_AAAA);
    endtask

    task automatic test_window_edges;
        longint unsigned mid;
        set_schedule(100, 200, 8, 17, 0, rtwc_pkg::UNIT_NONE);
        mid = 150 * DAY_MS;
        send_query(mid);
        send_query(mid + 8 * HOUR_MS - 1);
        send_query(mid + 8 * HOUR_MS);
        send_query(mid + 17 * HOUR_MS);
        send_query(mid + 17 * HOUR_MS + 1);
        send_query(mid + DAY_MS - 1);
        send_query(99 * DAY_MS + 9 * HOUR_MS);
        send_query(201 * DAY_MS + 9 * HOUR_MS);
    endtask

    task automatic test_odd_schedules;
        // first day after last day
        set_schedule(300, 299, 0, 24, 1, rtwc_pkg::UNIT_DAY);
        send_query(300 * DAY_MS + 5);
        // zero repeat count on a repeating unit
        set_schedule(10, 2097151, 2, 5, 0, rtwc_pkg::UNIT_MONTH);
        send_query(10 * DAY_MS + 3 * HOUR_MS);
        // hours above 24 saturate, start beyond end
        set_schedule(0, 2097151, 31, 31, 65535, rtwc_pkg::UNIT_YEAR);
        send_query(DAY_MS - 1);
        set_schedule(0, 2097151, 20, 4, 1, rtwc_pkg::UNIT_DAY);
        send_query(3 * HOUR_MS);
        send_query(12 * HOUR_MS);
        send_query(22 * HOUR_MS);
        send_query(TIME_MAX);
    endtask

    function automatic longint unsigned pick_day;
        longint unsigned k;
        longint y0, m0, d0, idx;
        to_civil(sched_first, y0, m0, d0);
        k = $urandom_range(0, 12);
        case (sched_unit)
            rtwc_pkg::UNIT_DAY:   return sched_first + k * sched_cnt;
            rtwc_pkg::UNIT_MONTH: begin
                idx = m0 - 1 + longint'(k * sched_cnt);
                return from_civil(y0 + idx / 12, idx % 12 + 1, d0);
            end
            rtwc_pkg::UNIT_YEAR:  return from_civil(y0 + longint'(k * sched_cnt), m0, d0);
            default:              return sched_first + $urandom_range(0, 400);
        endcase
    endfunction

    function automatic longint unsigned pick_time;
        longint unsigned day, tod, sh, eh;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: day = pick_day();
            6, 7:             day = sched_first + $urandom_range(0, 3000);
            8:                day = sched_first - $urandom_range(0, 3);
            default:          return {$urandom, $urandom} & TIME_MAX;
        endcase
        sh = (sched_sh > 24) ? 24 : sched_sh;
        eh = (sched_eh > 24) ? 24 : sched_eh;
        case ($urandom_range(0, 5))
            0: tod = sh * HOUR_MS + $urandom_range(0, 2) - 1;
            1: tod = eh * HOUR_MS + $urandom_range(0, 2) - 1;
            2: tod = $urandom_range(0, 1) ? 0 : DAY_MS - 1;
            default: tod = $urandom_range(0, DAY_MS - 1);
        endcase
        if (tod >= DAY_MS) tod = $urandom_range(0, DAY_MS - 1);
        return (day * DAY_MS + tod) & TIME_MAX;
    endfunction

    task automatic test_random_schedules;
        longint unsigned first, last, sh, eh, cnt, unit;
        for (int ph = 0; ph < 9; ph++) begin
            first = $urandom_range(0, 8) == 0 ? $urandom_range(0, 1628000)
                                              : $urandom_range(0, 30000);
            if (ph == 0) first = 0;
            last  = $urandom_range(0, 5) == 0 ? 2097151 : first + $urandom_range(0, 5000);
            if ($urandom_range(0, 9) == 0) last = first - 1;
            sh    = $urandom_range(0, 23);
            eh    = $urandom_range(sh + 1, 24);
            if ($urandom_range(0, 5) == 0) begin
                sh = $urandom_range(0, 31);
                eh = $urandom_range(0, 31);
            end
            cnt   = $urandom_range(1, 40);
            case ($urandom_range(0, 9))
                0: cnt = 0;
                1: cnt = 65535;
                2: cnt = $urandom_range(0, 65535);
                default: ;
            endcase
            unit  = ph % 4;
            set_schedule(first, last, sh, eh, cnt, unit);
            idling = (ph < 8);
            for (int n = 0; n < 50; n++) begin
                send_query(pick_time());
                if (ph == 3 && n == 25) drain_results();
            end
        end
    endtask

    initial begin
        errors      = 0;
        idling      = 1'b1;
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_time_ms   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_addr  = rtwc_pkg::CFG_FIRST_DAY;
        i_cfg_wdata = '0;
        sched_first = 0;
        sched_last  = 0;
        sched_sh    = 0;
        sched_eh    = 24;
        sched_cnt   = 0;
        sched_unit  = rtwc_pkg::UNIT_NONE;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_window_edges();
        test_odd_schedules();
        test_random_schedules();

        drain_results();
        if (errors == 0) begin
            $display("[repeating_time_window_check] OK");
        end else begin
            $display("[repeating_time_window_check] ERROR");
        end
        $finish;
    end
endmodule

// ----- repeating_time_window_check.f -----
+incdir+hdl
hdl/rtwc_pkg.sv
hdl/rtwc_civil.sv
hdl/rtwc_rem.sv
hdl/repeating_time_window_check.sv
hdl/rtwc_check.sv
tb/tb.sv
